/* hdl/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg: shared types, codes and character classes of the header tokenizer
// Holds the item structs, the token kind codes, the lexer mode encoding and
// the byte classification functions used by the front and back parts.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Default width of the byte and line counters.
    localparam int COUNT_WIDTH_DEF = 32;

    // Candidate token slots released by one byte: two from the pending token
    // (or a direct multi-byte punctuation), one single-byte token, two from the
    // final flush and the end token.
    localparam int NCAND = 6;
    localparam int SEL_W = $clog2(NCAND);

    // Bundle queue between the front and the back part.
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    // Token kinds.
    localparam logic [4:0] K_END      = 5'd0;
    localparam logic [4:0] K_SEMI     = 5'd1;
    localparam logic [4:0] K_COMMA    = 5'd2;
    localparam logic [4:0] K_LBRACE   = 5'd3;
    localparam logic [4:0] K_RBRACE   = 5'd4;
    localparam logic [4:0] K_LPAREN   = 5'd5;
    localparam logic [4:0] K_RPAREN   = 5'd6;
    localparam logic [4:0] K_LBRACK   = 5'd7;
    localparam logic [4:0] K_RBRACK   = 5'd8;
    localparam logic [4:0] K_STAR     = 5'd9;
    localparam logic [4:0] K_AMP      = 5'd10;
    localparam logic [4:0] K_EQUAL    = 5'd11;
    localparam logic [4:0] K_HASH     = 5'd12;
    localparam logic [4:0] K_TILDE    = 5'd13;
    localparam logic [4:0] K_LESS     = 5'd14;
    localparam logic [4:0] K_GREATER  = 5'd15;
    localparam logic [4:0] K_COLON    = 5'd16;
    localparam logic [4:0] K_DCOLON   = 5'd17;
    localparam logic [4:0] K_ELLIPSIS = 5'd18;
    localparam logic [4:0] K_DOT      = 5'd19;
    localparam logic [4:0] K_HEX      = 5'd20;
    localparam logic [4:0] K_INT      = 5'd21;
    localparam logic [4:0] K_NEG      = 5'd22;
    localparam logic [4:0] K_IDENT    = 5'd23;
    localparam logic [4:0] K_UNKNOWN  = 5'd24;

    // Characters the lexer treats specially.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Lexer modes, one-hot.
    typedef enum logic [14:0] {
        M_IDLE   = 15'b000000000000001,
        M_SLASH  = 15'b000000000000010,
        M_LINE   = 15'b000000000000100,
        M_BLOCK  = 15'b000000000001000,
        M_BSTAR  = 15'b000000000010000,
        M_COLON  = 15'b000000000100000,
        M_DOT1   = 15'b000000001000000,
        M_DOT2   = 15'b000000010000000,
        M_MINUS  = 15'b000000100000000,
        M_ZERO   = 15'b000001000000000,
        M_DEC    = 15'b000010000000000,
        M_HEX    = 15'b000100000000000,
        M_SUFDEC = 15'b001000000000000,
        M_SUFHEX = 15'b010000000000000,
        M_IDENT  = 15'b100000000000000
    } mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_final;
    } byte_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [31:0] start_line;
        logic        run_end;
    } token_t;

    // All tokens released by one accepted byte, in output order.
    typedef struct packed {
        logic [NCAND-1:0]   mask;
        token_t [NCAND-1:0] tok;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // u, U, l and L close a numeric literal.
    function automatic logic is_suffix(input logic [7:0] c);
        return c inside {8'h55, 8'h75, 8'h4C, 8'h6C};
    endfunction

    function automatic logic is_identc(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOLLAR);
    endfunction

    // Kind of a single-byte punctuation token; K_END means the byte is not one.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2A:   k = K_STAR;
            8'h26:   k = K_AMP;
            8'h3D:   k = K_EQUAL;
            8'h23:   k = K_HASH;
            8'h7E:   k = K_TILDE;
            8'h3C:   k = K_LESS;
            8'h3E:   k = K_GREATER;
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage

/* hdl/cht_front.sv */
// ----------------------------------------------------------------------------
// cht_front: byte classifier and lexer state
// Takes one byte per cycle while the queue has room, advances the lexer mode
// and counters, and queues the tokens released by that byte as one bundle.
// ----------------------------------------------------------------------------
module cht_front #(
    parameter int COUNT_WIDTH = cht_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  cht_pkg::byte_item_t byte_item,
    input  logic                q_full,
    output logic                push,
    output cht_pkg::bundle_t    push_bundle
);

    localparam int CW = COUNT_WIDTH;

    typedef struct packed {
        logic          v;
        logic [4:0]    kind;
        logic [CW-1:0] s;
        logic [CW-1:0] e;
        logic [CW-1:0] l;
    } cand_t;

    typedef struct packed {
        cand_t a;
        cand_t b;
    } cand_pair_t;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
        return (x == {CW{1'b1}}) ? x : x + CW'(1);
    endfunction

    function automatic logic [31:0] clamp32(input logic [CW-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic cand_t mk(input logic [4:0] k, input logic [CW-1:0] s,
                                 input logic [CW-1:0] e, input logic [CW-1:0] l);
        cand_t r;
        r.v    = 1'b1;
        r.kind = k;
        r.s    = s;
        r.e    = e;
        r.l    = l;
        return r;
    endfunction

    // Tokens that the pending token turns into when it is cut off at endp.
    function automatic cand_pair_t flush_pending(input cht_pkg::mode_t m, input logic neg,
                                                 input logic [CW-1:0] ps,
                                                 input logic [CW-1:0] pl,
                                                 input logic [CW-1:0] endp);
        cand_pair_t r;
        logic [4:0] nk;
        r  = '0;
        nk = neg ? cht_pkg::K_NEG :
             ((m == cht_pkg::M_HEX || m == cht_pkg::M_SUFHEX) ? cht_pkg::K_HEX
                                                             : cht_pkg::K_INT);
        case (m)
            cht_pkg::M_SLASH, cht_pkg::M_MINUS:
                r.a = mk(cht_pkg::K_UNKNOWN, ps, sat_inc(ps), pl);
            cht_pkg::M_COLON:
                r.a = mk(cht_pkg::K_COLON, ps, sat_inc(ps), pl);
            cht_pkg::M_DOT1:
                r.a = mk(cht_pkg::K_DOT, ps, sat_inc(ps), pl);
            cht_pkg::M_DOT2:
            begin
                r.a = mk(cht_pkg::K_DOT, ps, sat_inc(ps), pl);
                r.b = mk(cht_pkg::K_DOT, sat_inc(ps), sat_inc(sat_inc(ps)), pl);
            end
            cht_pkg::M_ZERO, cht_pkg::M_DEC, cht_pkg::M_HEX,
            cht_pkg::M_SUFDEC, cht_pkg::M_SUFHEX:
                r.a = mk(nk, ps, endp, pl);
            cht_pkg::M_IDENT:
                r.a = mk(cht_pkg::K_IDENT, ps, endp, pl);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic cht_pkg::token_t to_tok(input cand_t x);
        cht_pkg::token_t t;
        t.token_kind   = x.kind;
        t.start_offset = clamp32(x.s);
        t.token_length = clamp32((x.e >= x.s) ? x.e - x.s : '0);
        t.start_line   = clamp32(x.l);
        t.run_end      = 1'b0;
        return t;
    endfunction

    cht_pkg::mode_t mode_reg, mode_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  line_reg, line_next;
    logic [CW-1:0]  ps_reg, ps_next;
    logic [CW-1:0]  pl_reg, pl_next;
    logic           neg_reg, neg_next;

    logic [7:0]     c;
    logic           fin;
    logic           accept;
    logic           relex;
    logic           do_flush;
    logic [4:0]     sk;
    cand_pair_t     fl1, fl2;
    cand_t          direct, single, endc;
    cand_t [cht_pkg::NCAND-1:0] cands;

    assign c          = byte_item.char_byte;
    assign fin        = byte_item.is_final;
    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign sk         = cht_pkg::single_kind(c);

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        ps_next   = ps_reg;
        pl_next   = pl_reg;
        neg_next  = neg_reg;
        relex     = 1'b0;
        do_flush  = 1'b0;
        direct    = '0;
        single    = '0;

        case (mode_reg)
            cht_pkg::M_SLASH:
                if (c == cht_pkg::CH_SLASH)
                    mode_next = cht_pkg::M_LINE;
                else if (c == cht_pkg::CH_STAR)
                    mode_next = cht_pkg::M_BLOCK;
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_LINE:
                if (c == cht_pkg::CH_NL)
                begin
                    line_next = sat_inc(line_reg);
                    mode_next = cht_pkg::M_IDLE;
                end
            cht_pkg::M_BLOCK, cht_pkg::M_BSTAR:
                if (mode_reg == cht_pkg::M_BSTAR && c == cht_pkg::CH_SLASH)
                    mode_next = cht_pkg::M_IDLE;
                else if (fin)
                    relex = 1'b1;
                else if (c == cht_pkg::CH_STAR)
                    mode_next = cht_pkg::M_BSTAR;
                else
                begin
                    if (c == cht_pkg::CH_NL)
                        line_next = sat_inc(line_reg);
                    mode_next = cht_pkg::M_BLOCK;
                end
            cht_pkg::M_COLON:
                if (c == cht_pkg::CH_COLON)
                begin
                    direct    = mk(cht_pkg::K_DCOLON, ps_reg, sat_inc(pos_reg), pl_reg);
                    mode_next = cht_pkg::M_IDLE;
                end
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_DOT1:
                if (c == cht_pkg::CH_DOT)
                    mode_next = cht_pkg::M_DOT2;
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_DOT2:
                if (c == cht_pkg::CH_DOT)
                begin
                    direct    = mk(cht_pkg::K_ELLIPSIS, ps_reg, sat_inc(pos_reg), pl_reg);
                    mode_next = cht_pkg::M_IDLE;
                end
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_MINUS:
                if (cht_pkg::is_digit(c))
                begin
                    mode_next = (c == cht_pkg::CH_ZERO) ? cht_pkg::M_ZERO : cht_pkg::M_DEC;
                    neg_next  = 1'b1;
                end
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_ZERO:
                if (c == cht_pkg::CH_X_LO || c == cht_pkg::CH_X_UP)
                    mode_next = cht_pkg::M_HEX;
                else if (cht_pkg::is_digit(c))
                    mode_next = cht_pkg::M_DEC;
                else if (cht_pkg::is_suffix(c))
                    mode_next = cht_pkg::M_SUFDEC;
                else
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_DEC:
                if (cht_pkg::is_suffix(c))
                    mode_next = cht_pkg::M_SUFDEC;
                else if (!cht_pkg::is_digit(c))
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_HEX:
                if (cht_pkg::is_suffix(c))
                    mode_next = cht_pkg::M_SUFHEX;
                else if (!cht_pkg::is_xdigit(c))
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_SUFDEC, cht_pkg::M_SUFHEX:
                if (!cht_pkg::is_suffix(c))
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            cht_pkg::M_IDENT:
                if (!cht_pkg::is_identc(c))
                begin
                    do_flush = 1'b1;
                    relex    = 1'b1;
                end
            default:
                relex = 1'b1;
        endcase

        // The byte as it would be lexed between tokens.
        if (relex)
        begin
            mode_next = cht_pkg::M_IDLE;
            if (cht_pkg::is_space(c))
            begin
                if (c == cht_pkg::CH_NL)
                    line_next = sat_inc(line_reg);
            end
            else if (sk != cht_pkg::K_END)
                single = mk(sk, pos_reg, sat_inc(pos_reg), line_reg);
            else if (c == cht_pkg::CH_SLASH || c == cht_pkg::CH_COLON ||
                     c == cht_pkg::CH_DOT || c == cht_pkg::CH_MINUS ||
                     cht_pkg::is_digit(c) || cht_pkg::is_alpha(c) ||
                     c == cht_pkg::CH_UNDER || c == cht_pkg::CH_DOLLAR)
            begin
                ps_next = pos_reg;
                pl_next = line_reg;
                if (c == cht_pkg::CH_SLASH)
                    mode_next = cht_pkg::M_SLASH;
                else if (c == cht_pkg::CH_COLON)
                    mode_next = cht_pkg::M_COLON;
                else if (c == cht_pkg::CH_DOT)
                    mode_next = cht_pkg::M_DOT1;
                else if (c == cht_pkg::CH_MINUS)
                    mode_next = cht_pkg::M_MINUS;
                else if (cht_pkg::is_digit(c))
                begin
                    mode_next = (c == cht_pkg::CH_ZERO) ? cht_pkg::M_ZERO : cht_pkg::M_DEC;
                    neg_next  = 1'b0;
                end
                else
                    mode_next = cht_pkg::M_IDENT;
            end
            else
                single = mk(cht_pkg::K_UNKNOWN, pos_reg, sat_inc(pos_reg), line_reg);
        end

        fl1 = '0;
        if (do_flush)
            fl1 = flush_pending(mode_reg, neg_reg, ps_reg, pl_reg, pos_reg);
        else
            fl1.a = direct;

        pos_next = sat_inc(pos_reg);

        fl2  = '0;
        endc = '0;
        if (fin)
        begin
            fl2  = flush_pending(mode_next, neg_next, ps_next, pl_next, pos_next);
            endc = mk(cht_pkg::K_END, pos_next, pos_next, line_next);
        end
    end

    assign cands = {endc, fl2.b, fl2.a, single, fl1.b, fl1.a};

    always_comb
    begin
        for (int i = 0; i < cht_pkg::NCAND; i++)
        begin
            push_bundle.mask[i] = cands[i].v;
            push_bundle.tok[i]  = to_tok(cands[i]);
        end
    end

    assign push = accept && (|push_bundle.mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cht_pkg::M_IDLE;
            pos_reg  <= '0;
            line_reg <= CW'(1);
            ps_reg   <= '0;
            pl_reg   <= CW'(1);
            neg_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (fin)
            begin
                mode_reg <= cht_pkg::M_IDLE;
                pos_reg  <= '0;
                line_reg <= CW'(1);
                ps_reg   <= '0;
                pl_reg   <= CW'(1);
                neg_reg  <= 1'b0;
            end
            else
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                line_reg <= line_next;
                ps_reg   <= ps_next;
                pl_reg   <= pl_next;
                neg_reg  <= neg_next;
            end
        end
    end

endmodule

/* hdl/cht_queue.sv */
// ----------------------------------------------------------------------------
// cht_queue: bundle queue between the lexer and the token sender
// A small first-in first-out store of token bundles.
// ----------------------------------------------------------------------------
module cht_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cht_pkg::bundle_t push_bundle,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cht_pkg::bundle_t head
);

    cht_pkg::bundle_t              mem_reg [cht_pkg::QDEPTH];
    logic [cht_pkg::QA_W-1:0]      wr_reg, wr_next;
    logic [cht_pkg::QA_W-1:0]      rd_reg, rd_next;
    logic [cht_pkg::QA_W:0]        cnt_reg, cnt_next;

    assign full       = (cnt_reg == (cht_pkg::QA_W + 1)'(cht_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + (cht_pkg::QA_W)'(1) : wr_reg;
        rd_next  = pop ? rd_reg + (cht_pkg::QA_W)'(1) : rd_reg;
        cnt_next = cnt_reg + (cht_pkg::QA_W + 1)'(push) - (cht_pkg::QA_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hdl/cht_back.sv */
// ----------------------------------------------------------------------------
// cht_back: token sender
// Walks the head bundle's valid slots and, unless the output stalls, sends
// one token per cycle through an output register, marking each bundle's last.
// ----------------------------------------------------------------------------
module cht_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cht_pkg::bundle_t head,
    output logic             pop,
    output logic             tok_valid,
    input  logic             tok_stall,
    output cht_pkg::token_t  tok_item
);

    logic [cht_pkg::NCAND-1:0] done_reg, done_next;
    logic [cht_pkg::NCAND-1:0] avail;
    logic [cht_pkg::NCAND-1:0] sel_oh;
    logic [cht_pkg::SEL_W-1:0] sel;
    logic                      last;
    logic                      load;
    logic                      tok_valid_reg, tok_valid_next;
    cht_pkg::token_t           tok_item_reg, tok_item_next;

    assign avail = head.mask & ~done_reg;

    // Lowest remaining slot goes first.
    always_comb
    begin
        sel = '0;
        for (int i = cht_pkg::NCAND - 1; i >= 0; i--)
        begin
            if (avail[i])
                sel = cht_pkg::SEL_W'(i);
        end
    end

    assign sel_oh = cht_pkg::NCAND'(1) << sel;
    assign last   = ((avail & ~sel_oh) == '0);
    assign load   = head_valid && (!tok_valid_reg || !tok_stall);
    assign pop    = load && last;

    always_comb
    begin
        done_next      = done_reg;
        tok_valid_next = tok_valid_reg;
        tok_item_next  = tok_item_reg;
        if (load)
        begin
            tok_item_next         = head.tok[sel];
            tok_item_next.run_end = last;
            tok_valid_next        = 1'b1;
            done_next             = last ? '0 : (done_reg | sel_oh);
        end
        else if (!tok_stall)
            tok_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_item_reg <= tok_item_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok_item  = tok_item_reg;

endmodule

/* hdl/c_header_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// c_header_tokenizer_core: streaming tokenizer for C header text
// Lexes one byte per item and delivers tokens as kind, start offset, length
// and start line, skipping whitespace and comments and counting lines.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Item
//  --------+-----------+---------------------------+---------------------------
//  byte    | in        | byte_valid / byte_stall   | char_byte, is_final
//  tok     | out       | tok_valid  / tok_stall    | kind, offset, length, line,
//          |           |                           | run_end
//
//  The front part accepts one byte in every cycle in which the bundle queue
//  has room; the lexer mode, byte position and line counters advance in that
//  same cycle. The tokens one byte releases (zero to four) travel as one
//  bundle through a four-entry queue, and the back part sends them one token
//  per cycle through a registered output while tok_stall is low, so each
//  token passes through the queue and the output register. Sustained rate is
//  one byte per cycle while each byte releases at most one token; a byte that
//  releases more sends its tokens in turn, and the queue absorbs such bursts.
//  Reset clears the lexer state, the queue pointers and the output valid.
//  A stall on the output fills the queue and then raises byte_stall.
//
//  The byte marked final flushes the pending token, appends the end token
//  and returns all lexer state to its reset values for the next text.
//
module c_header_tokenizer_core #(
    parameter int COUNT_WIDTH = cht_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  cht_pkg::byte_item_t byte_item,
    output logic                tok_valid,
    input  logic                tok_stall,
    output cht_pkg::token_t     tok_item
);

    logic             q_full;
    logic             push;
    logic             pop;
    logic             head_valid;
    cht_pkg::bundle_t push_bundle;
    cht_pkg::bundle_t head;

    // Lexer: classifies each byte and builds the bundle of released tokens.
    cht_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // Decouples the lexer from output stalls.
    cht_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head        (head)
    );

    // Serializes each bundle onto the token channel.
    cht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    // The lexer never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !push)
        else $error("bundle written into a full queue");

    // A bundle is only retired when one is present.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("bundle retired from an empty queue");

    // The end token is always the last token of its byte and has no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_item.token_kind == cht_pkg::K_END)
            |-> (tok_item.run_end && tok_item.token_length == 32'd0))
        else $error("end token not last or with nonzero length");

endmodule
